[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/icy_msd_pkg.sv]
package icy_msd_pkg;

    localparam int BYTE_W     = 8;
    localparam int INTERVAL_W = 20;
    localparam int SIZE_W     = 12;
    localparam int KIND_W     = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Tag codes carried on byte_kind.
    localparam logic [KIND_W-1:0] KIND_AUDIO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_META   = 2'd2;

    // Deframer phase codes.
    localparam logic PHASE_AUDIO = 1'b0;
    localparam logic PHASE_META  = 1'b1;

    // Register byte addresses.
    localparam logic [APB_ADDR_W-1:0] ADDR_META_INTERVAL = 3'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic [SIZE_W-1:0] size;
    } icy_msd_result_t;

endpackage

[sv/icy_metadata_stream_deframer_unit.sv]
// ICY metadata stream deframer.
// Input channel: in_valid / in_stall with one raw stream byte on data_byte.
// Output channel: out_valid / out_stall with the byte on out_byte, its tag on
// byte_kind (audio, length or metadata), meta_last on the final byte of a
// metadata block or on a zero length byte, and meta_size on a length byte.
// A request is taken at a clock edge where valid is high and stall is low.
// The meta_interval register (APB, offset 0) sets the audio bytes between
// blocks; zero passes every byte as audio. Write it only while idle.
// An accepted byte is loaded into the input register, and it moves on into
// the result register, where it can be taken, once that register is free.
// Throughput is one byte per cycle while the receiver does not stall; the
// counters update as each byte moves on into the result register.
// When the receiver stalls, the result holds and the input register fills,
// after which in_stall rises until the result is taken.
// Reset clears both registers' valid flags, the counters and the interval,
// so the block starts in the audio phase with metadata disabled.
module icy_metadata_stream_deframer_unit
    import icy_msd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     out_byte,
    output logic [KIND_W-1:0]     byte_kind,
    output logic                  meta_last,
    output logic [SIZE_W-1:0]     meta_size
);

    logic [INTERVAL_W-1:0] meta_interval;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    icy_msd_result_t       result;
    icy_msd_result_t       result_reg;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    icy_msd_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .meta_interval (meta_interval)
    );

    icy_msd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (in_byte_reg),
        .meta_interval (meta_interval),
        .result        (result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = result_reg.data;
    assign byte_kind = result_reg.kind;
    assign meta_last = result_reg.last;
    assign meta_size = result_reg.size;

endmodule

[sv/icy_msd_apb.sv]
module icy_msd_apb
    import icy_msd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [INTERVAL_W-1:0] meta_interval
);

    logic [INTERVAL_W-1:0] meta_interval_reg;
    logic [INTERVAL_W-1:0] meta_interval_next;
    logic                  wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == ADDR_META_INTERVAL);

    always_comb
    begin
        meta_interval_next = meta_interval_reg;
        if (wr_hit)
        begin
            meta_interval_next = pwdata[INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_interval_reg <= '0;
        end
        else
        begin
            meta_interval_reg <= meta_interval_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_META_INTERVAL)
        begin
            prdata = {{(APB_DATA_W-INTERVAL_W){1'b0}}, meta_interval_reg};
        end
    end

    assign meta_interval = meta_interval_reg;

endmodule

[sv/icy_msd_core.sv]
module icy_msd_core
    import icy_msd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic [INTERVAL_W-1:0] meta_interval,
    output icy_msd_result_t       result
);

    logic                  phase_reg;
    logic                  phase_next;
    logic [INTERVAL_W-1:0] audio_count_reg;
    logic [INTERVAL_W-1:0] audio_count_next;
    logic [SIZE_W-1:0]     meta_remaining_reg;
    logic [SIZE_W-1:0]     meta_remaining_next;
    logic [SIZE_W-1:0]     remaining_dec;
    logic [SIZE_W-1:0]     block_size;

    assign remaining_dec = (meta_remaining_reg != '0) ? (meta_remaining_reg - SIZE_W'(1))
                                                      : meta_remaining_reg;
    assign block_size    = {data_byte, 4'b0000};

    always_comb
    begin
        result.data         = data_byte;
        result.kind         = KIND_AUDIO;
        result.last         = 1'b0;
        result.size         = '0;
        phase_next          = phase_reg;
        audio_count_next    = audio_count_reg;
        meta_remaining_next = meta_remaining_reg;

        if (meta_interval == '0)
        begin
            // Metadata disabled: any block in progress is dropped.
            phase_next          = PHASE_AUDIO;
            audio_count_next    = '0;
            meta_remaining_next = '0;
        end
        else if (phase_reg == PHASE_META)
        begin
            result.kind         = KIND_META;
            meta_remaining_next = remaining_dec;
            if (remaining_dec == '0)
            begin
                result.last      = 1'b1;
                phase_next       = PHASE_AUDIO;
                audio_count_next = '0;
            end
        end
        else if (audio_count_reg < meta_interval)
        begin
            phase_next       = PHASE_AUDIO;
            audio_count_next = audio_count_reg + INTERVAL_W'(1);
        end
        else
        begin
            result.kind      = KIND_LENGTH;
            result.size      = block_size;
            audio_count_next = '0;
            if (data_byte == '0)
            begin
                // An empty block ends on its own length byte.
                result.last = 1'b1;
                phase_next  = PHASE_AUDIO;
            end
            else
            begin
                phase_next          = PHASE_META;
                meta_remaining_next = block_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PHASE_AUDIO;
            audio_count_reg    <= '0;
            meta_remaining_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            audio_count_reg    <= audio_count_next;
            meta_remaining_reg <= meta_remaining_next;
        end
    end

endmodule

[sv/icy_msd_checker.sv]
`include "assert_macros.svh"

module icy_msd_checker
    import icy_msd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] out_byte,
    input logic [KIND_W-1:0] byte_kind,
    input logic              meta_last,
    input logic [SIZE_W-1:0] meta_size
);

    // Audio bytes never close a metadata block.
    `ASSERT_SAME(a_audio_not_last, clk, rst_n,
                 out_valid && (byte_kind == KIND_AUDIO), !meta_last)

    // A length byte ends the block exactly when it announces zero bytes.
    `ASSERT_SAME(a_length_last, clk, rst_n,
                 out_valid && (byte_kind == KIND_LENGTH), meta_last == (meta_size == '0))

    // Only a length byte carries a block size.
    `ASSERT_SAME(a_size_on_length, clk, rst_n,
                 out_valid && (byte_kind != KIND_LENGTH), meta_size == '0)

    // A stalled result stays in place.
    `ASSERT_NEXT(a_stall_hold, clk, rst_n,
                 out_valid && out_stall,
                 out_valid && $stable(out_byte) && $stable(byte_kind) && $stable(meta_size))

endmodule

bind icy_metadata_stream_deframer_unit icy_msd_checker u_icy_msd_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import icy_msd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int STREAM_BYTES   = 1800;
    localparam int IDLE_PCT       = 22;
    localparam int PIPE_LATENCY   = 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;

    // Tracks the deframer's counters and holds the tagged bytes still owed by the block.
    class deframe_scoreboard;
        logic [INTERVAL_W-1:0] interval;
        logic                  phase;
        logic [INTERVAL_W-1:0] audio_count;
        logic [SIZE_W-1:0]     meta_left;
        icy_msd_result_t       tagged_bytes_due[$];
        int unsigned           errors;
        int unsigned           audio_seen;
        int unsigned           length_seen;
        int unsigned           meta_seen;

        function new();
            interval    = '0;
            phase       = PHASE_AUDIO;
            audio_count = '0;
            meta_left   = '0;
            errors      = 0;
            audio_seen  = 0;
            length_seen = 0;
            meta_seen   = 0;
        endfunction

        function void set_interval(logic [APB_DATA_W-1:0] word);
            interval = word[INTERVAL_W-1:0];
        endfunction

        function bit length_due();
            return interval != 0 && phase != PHASE_META && audio_count >= interval;
        endfunction

        function void note_stream_byte(logic [BYTE_W-1:0] value);
            icy_msd_result_t tag;
            tag.data = value;
            tag.kind = KIND_AUDIO;
            tag.last = 1'b0;
            tag.size = '0;
            if (interval == 0)
            begin
                // Metadata is off: any block in progress is dropped.
                phase       = PHASE_AUDIO;
                audio_count = '0;
                meta_left   = '0;
            end
            else if (phase == PHASE_META)
            begin
                tag.kind = KIND_META;
                if (meta_left != 0)
                    meta_left = meta_left - SIZE_W'(1);
                if (meta_left == 0)
                begin
                    tag.last    = 1'b1;
                    phase       = PHASE_AUDIO;
                    audio_count = '0;
                end
            end
            else if (audio_count < interval)
            begin
                audio_count = audio_count + INTERVAL_W'(1);
            end
            else
            begin
                tag.kind    = KIND_LENGTH;
                tag.size    = {value, 4'b0000};
                audio_count = '0;
                if (tag.size == 0)
                begin
                    tag.last = 1'b1;
                    phase    = PHASE_AUDIO;
                end
                else
                begin
                    phase     = PHASE_META;
                    meta_left = tag.size;
                end
            end
            tagged_bytes_due.push_back(tag);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_tagged_byte(icy_msd_result_t got);
            icy_msd_result_t want;
            if (tagged_bytes_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual byte 0x%0h kind %0d",
                         $time, got.data, got.kind);
                return;
            end
            want = tagged_bytes_due.pop_front();
            compare_field("out_byte", want.data, got.data);
            compare_field("byte_kind", want.kind, got.kind);
            compare_field("meta_last", want.last, got.last);
            compare_field("meta_size", want.size, got.size);
            if (want.kind == KIND_AUDIO)
                audio_seen++;
            else if (want.kind == KIND_LENGTH)
                length_seen++;
            else
                meta_seen++;
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic [KIND_W-1:0]     byte_kind;
    logic                  meta_last;
    logic [SIZE_W-1:0]     meta_size;

    deframe_scoreboard sb;
    bit                no_idle        = 1'b0;
    int unsigned       bytes_sent     = 0;
    int unsigned       settings_used  = 0;
    int unsigned       quiet_cycles   = 0;

    icy_metadata_stream_deframer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .byte_kind (byte_kind),
        .meta_last (meta_last),
        .meta_size (meta_size)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        out_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if (out_valid && !out_stall)
                sb.check_tagged_byte(icy_msd_result_t'{out_byte, byte_kind, meta_last, meta_size});
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired after %0d cycles without a handshake",
                         $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid  = 1'b0;
            data_byte = BYTE_W'($urandom);
            @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = value;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_stream_byte(value);
        bytes_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.tagged_bytes_due.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 1) @(negedge clk);
    endtask

    // The register only changes while the pipeline is empty; each write is read back.
    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word                   = $urandom;
        word[INTERVAL_W-1:0]   = value;
        wait_drained();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_META_INTERVAL;
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_interval(word);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[INTERVAL_W-1:0] !== value)
        begin
            sb.errors++;
            $display("%0t: meta_interval readback mismatch, expected 0x%0h, actual 0x%0h",
                     $time, value, prdata[INTERVAL_W-1:0]);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        settings_used++;
    endtask

    // Length bytes are mostly short so that blocks stay small; now and then a long one.
    function automatic logic [BYTE_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return '0;
        else if (roll < 90)
            return BYTE_W'($urandom_range(1, 3));
        else if (roll < 97)
            return BYTE_W'($urandom_range(4, 12));
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int unsigned           phase_idx;
        int unsigned           burst;
        logic [INTERVAL_W-1:0] interval;
        sb = new();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Metadata is off after reset, so these are audio.
        send_byte(8'h00);
        send_byte(8'hFF);

        // Interval one: a zero length byte, then a single sixteen byte block.
        write_interval(20'd1);
        send_byte(8'h12);
        send_byte(8'h00);
        send_byte(8'hED);
        send_byte(8'h01);
        for (int i = 0; i < 16; i++)
            send_byte(8'h80 ^ i[7:0]);

        // Lowering the interval below the current count makes the next byte a length byte.
        write_interval(20'd5);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h0F);
        write_interval(20'd2);
        send_byte(8'hFF);
        send_byte(8'hF0);

        // Turning metadata off abandons the block that was just started.
        write_interval(20'd0);
        send_byte(8'h3C);

        phase_idx = 0;
        while (bytes_sent < STREAM_BYTES)
        begin
            if (phase_idx == 1)
                interval = INTERVAL_MAX;
            else
            begin
                case ($urandom_range(0, 9))
                    0:       interval = '0;
                    1:       interval = INTERVAL_MAX;
                    2:       interval = INTERVAL_W'($urandom);
                    default: interval = INTERVAL_W'($urandom_range(1, 24));
                endcase
            end
            no_idle = (phase_idx == 4);
            write_interval(interval);
            burst = $urandom_range(40, 160);
            repeat (burst)
            begin
                if (sb.length_due())
                    send_byte(pick_length());
                else
                    send_byte(BYTE_W'($urandom));
            end
            phase_idx++;
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (8) @(negedge clk);

        $display("Streamed %0d bytes under %0d interval settings.", bytes_sent, settings_used);
        $display("Checked %0d audio, %0d length and %0d metadata bytes.",
                 sb.audio_seen, sb.length_seen, sb.meta_seen);
        if (sb.errors == 0 && sb.tagged_bytes_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
